FILE: rtl/core/utf8x_pkg.sv
// utf8x_pkg: shared types and constants for the XML-text UTF-8 validator.
// Used by utf8x_front, utf8x_fifo, utf8x_back, utf8_xml_text_validator and utf8x_checker.
package utf8x_pkg;

  localparam logic [31:0] CP_LIMIT      = 32'h0011_0000;
  localparam logic [31:0] SURR_MASK     = 32'hFFFF_F800;
  localparam logic [31:0] SURR_BASE     = 32'h0000_D800;
  localparam logic [31:0] NONCHAR_LO    = 32'h0000_FDD0;
  localparam logic [31:0] NONCHAR_HI    = 32'h0000_FDEF;
  localparam logic [31:0] NONCHAR_END   = 32'h0000_FFFE;
  localparam logic [7:0]  CONT_TAG_MASK = 8'hC0;
  localparam logic [7:0]  CONT_TAG      = 8'h80;

  localparam int QDEPTH = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);

  localparam logic [2:0] LEN_BAD = 3'd0;

  // classified byte, front to back
  typedef struct packed {
    logic       take;      // byte goes through the sequence checker
    logic       emit;      // string ends after this byte
    logic       is_zero;
    logic       is_cont;
    logic [2:0] lead_len;  // LEN_BAD for an illegal lead byte
    logic [6:0] bits;      // lead payload bits, or raw low bits otherwise
  } byte_class_t;

  function automatic logic [2:0] needed_length(input logic [30:0] cp);
    logic [2:0] n;
    if (cp < 31'h80) n = 3'd1;
    else if (cp < 31'h800) n = 3'd2;
    else if (cp < 31'h1_0000) n = 3'd3;
    else if (cp < 31'h20_0000) n = 3'd4;
    else if (cp < 31'h400_0000) n = 3'd5;
    else n = 3'd6;
    return n;
  endfunction

  function automatic logic cp_allowed(input logic [30:0] cp);
    logic [31:0] w;
    logic        ok;
    w  = {1'b0, cp};
    ok = 1'b1;
    if (w >= CP_LIMIT) ok = 1'b0;
    if ((w & SURR_MASK) == SURR_BASE) ok = 1'b0;
    if (w >= NONCHAR_LO && w <= NONCHAR_HI) ok = 1'b0;
    if (w < 32'h20 && w != 32'h09 && w != 32'h0A && w != 32'h0D) ok = 1'b0;
    if ((w & NONCHAR_END) == NONCHAR_END) ok = 1'b0;
    return ok;
  endfunction

endpackage

FILE: rtl/core/utf8x_front.sv
// utf8x_front: accepts bytes and classifies each one (lead length, payload,
// string end). Depends on utf8x_pkg.
module utf8x_front import utf8x_pkg::*; (
  input  logic        nul_terminated,
  input  logic [7:0]  data_byte,
  input  logic        last,
  output byte_class_t cls
);

  logic [2:0] len;
  logic [6:0] mask;

  always_comb begin
    len  = LEN_BAD;
    mask = 7'h7F;
    if (data_byte[7] == 1'b0) begin
      len = 3'd1; mask = 7'h7F;
    end else if (data_byte[7:5] == 3'b110) begin
      len = 3'd2; mask = 7'h1F;
    end else if (data_byte[7:4] == 4'b1110) begin
      len = 3'd3; mask = 7'h0F;
    end else if (data_byte[7:3] == 5'b11110) begin
      len = 3'd4; mask = 7'h07;
    end else if (data_byte[7:2] == 6'b111110) begin
      len = 3'd5; mask = 7'h03;
    end else if (data_byte[7:1] == 7'b1111110) begin
      len = 3'd6; mask = 7'h01;
    end
  end

  always_comb begin
    cls.is_zero  = (data_byte == 8'h00);
    cls.is_cont  = ((data_byte & CONT_TAG_MASK) == CONT_TAG);
    cls.lead_len = len;
    cls.bits     = data_byte[6:0] & mask;
    cls.take     = !(nul_terminated && cls.is_zero);
    cls.emit     = nul_terminated ? cls.is_zero : last;
  end

endmodule

FILE: rtl/core/utf8x_fifo.sv
// utf8x_fifo: short queue of classified bytes between front and back.
// Depends on utf8x_pkg.
module utf8x_fifo import utf8x_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  byte_class_t push_data,
  output logic        full,
  input  logic        pop,
  output logic        not_empty,
  output byte_class_t pop_data
);

  byte_class_t          mem [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;

  assign full      = (count == (QPTR_BITS + 1)'(QDEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/core/utf8x_back.sv
// utf8x_back: sequence checker and valid-prefix counter, with the result
// register. Depends on utf8x_pkg.
module utf8x_back import utf8x_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  byte_class_t q_data,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        valid_res,
  output logic [15:0] prefix_length
);

  localparam int EXT_BITS = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  logic                  error_seen, error_seen_next;
  logic [2:0]            bytes_remaining, bytes_remaining_next;
  logic [2:0]            sequence_length, sequence_length_next;
  logic [30:0]           partial_code_point, partial_code_point_next;
  logic [COUNT_BITS-1:0] valid_count, valid_count_next;

  logic [COUNT_BITS:0]   sum;
  logic [EXT_BITS-1:0]   cnt_ext;
  logic                  finish;

  assign q_pop = q_valid && (!q_data.emit || !out_valid || out_ready);

  always_comb begin
    error_seen_next         = error_seen;
    bytes_remaining_next    = bytes_remaining;
    sequence_length_next    = sequence_length;
    partial_code_point_next = partial_code_point;
    valid_count_next        = valid_count;
    finish                  = 1'b0;
    sum                     = '0;

    if (q_data.take && !error_seen) begin
      if (q_data.is_zero) begin
        error_seen_next = 1'b1;
      end else if (bytes_remaining != 3'd0) begin
        if (!q_data.is_cont) begin
          error_seen_next = 1'b1;
        end else begin
          partial_code_point_next = {partial_code_point[24:0], q_data.bits[5:0]};
          bytes_remaining_next    = bytes_remaining - 3'd1;
          finish                  = (bytes_remaining == 3'd1);
        end
      end else if (q_data.lead_len == LEN_BAD) begin
        error_seen_next = 1'b1;
      end else begin
        sequence_length_next    = q_data.lead_len;
        partial_code_point_next = {24'd0, q_data.bits};
        bytes_remaining_next    = q_data.lead_len - 3'd1;
        finish                  = (q_data.lead_len == 3'd1);
      end
    end

    if (finish) begin
      if (needed_length(partial_code_point_next) != sequence_length_next ||
          !cp_allowed(partial_code_point_next)) begin
        error_seen_next = 1'b1;
      end else begin
        sum = {1'b0, valid_count} + (COUNT_BITS + 1)'(sequence_length_next);
        valid_count_next = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
      end
      bytes_remaining_next    = 3'd0;
      sequence_length_next    = 3'd0;
      partial_code_point_next = '0;
    end
  end

  assign cnt_ext = EXT_BITS'(valid_count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      error_seen         <= 1'b0;
      bytes_remaining    <= 3'd0;
      sequence_length    <= 3'd0;
      partial_code_point <= '0;
      valid_count        <= '0;
      out_valid          <= 1'b0;
    end else begin
      if (q_pop) begin
        if (q_data.emit) begin
          error_seen         <= 1'b0;
          bytes_remaining    <= 3'd0;
          sequence_length    <= 3'd0;
          partial_code_point <= '0;
          valid_count        <= '0;
        end else begin
          error_seen         <= error_seen_next;
          bytes_remaining    <= bytes_remaining_next;
          sequence_length    <= sequence_length_next;
          partial_code_point <= partial_code_point_next;
          valid_count        <= valid_count_next;
        end
      end
      if (q_pop && q_data.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_data.emit) begin
      valid_res     <= !error_seen_next && (bytes_remaining_next == 3'd0);
      prefix_length <= (cnt_ext > EXT_BITS'(16'hFFFF)) ? 16'hFFFF : cnt_ext[15:0];
    end
  end

endmodule

FILE: rtl/core/utf8_xml_text_validator.sv
// utf8_xml_text_validator: top level of the XML-text UTF-8 validator.
// Depends on utf8x_pkg, utf8x_front, utf8x_fifo, utf8x_back.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   data_byte[7:0], last
//   out      output     out_valid / out_ready valid_res, prefix_length[15:0]
//   cfg      input      cfg_wr_en             cfg_wr_data (nul_terminated)
//
// One byte per cycle sustained while out_ready takes results. A result is presented
// from the edge that pops its ending byte; that byte is first written into the queue.
// The 4-entry queue takes bytes while a result waits on out_ready.
// rst is synchronous: clears the queue, string state and the mode register.
module utf8_xml_text_validator import utf8x_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        valid_res,
  output logic [15:0] prefix_length
);

  logic        nul_terminated;
  byte_class_t cls;
  byte_class_t q_data;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;

  always_ff @(posedge clk) begin
    if (rst) nul_terminated <= 1'b0;
    else if (cfg_wr_en) nul_terminated <= cfg_wr_data;
  end

  assign in_ready = !q_full;

  utf8x_front u_front (
    .nul_terminated (nul_terminated),
    .data_byte      (data_byte),
    .last           (last),
    .cls            (cls)
  );

  utf8x_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && in_ready),
    .push_data (cls),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  utf8x_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .valid_res     (valid_res),
    .prefix_length (prefix_length)
  );

endmodule

FILE: dv/utf8x_checker.sv
// utf8x_checker: watches the byte, result and mode ports of the XML-text UTF-8 validator,
// predicts each string verdict and compares it with what the block returns.
// Depends on utf8x_pkg for the code point limits.
module utf8x_checker import utf8x_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        valid_res,
  input  logic [15:0] prefix_length,
  output int          fail_count,
  output int          verdicts_due,
  output int          verdicts_done,
  output int          verdicts_ok
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] CH_TAB   = 32'h09;
  localparam logic [31:0] CH_LF    = 32'h0A;
  localparam logic [31:0] CH_CR    = 32'h0D;
  localparam logic [31:0] CH_SPACE = 32'h20;

  typedef struct packed {
    logic        ok;
    logic [15:0] plen;
  } verdict_t;

  verdict_t    verdict_q[$];
  logic        nul_mode;
  logic        str_err;
  logic [2:0]  seq_left;
  logic [2:0]  seq_len;
  logic [30:0] code_acc;
  logic [15:0] good_bytes;
  int          n_fail = 0;
  int          n_done = 0;
  int          n_ok = 0;

  function automatic logic [2:0] enc_bytes(input logic [30:0] cp);
    if (cp < 31'h80) return 3'd1;
    if (cp < 31'h800) return 3'd2;
    if (cp < 31'h1_0000) return 3'd3;
    if (cp < 31'h20_0000) return 3'd4;
    if (cp < 31'h400_0000) return 3'd5;
    return 3'd6;
  endfunction

  function automatic logic xml_char_ok(input logic [30:0] cp);
    logic [31:0] w;
    w = {1'b0, cp};
    if (w >= CP_LIMIT) return 1'b0;
    if ((w & SURR_MASK) == SURR_BASE) return 1'b0;
    if (w >= NONCHAR_LO && w <= NONCHAR_HI) return 1'b0;
    if (w < CH_SPACE && w != CH_TAB && w != CH_LF && w != CH_CR) return 1'b0;
    return (w & NONCHAR_END) != NONCHAR_END;
  endfunction

  task automatic clear_string();
    str_err = 1'b0;
    seq_left = '0;
    seq_len = '0;
    code_acc = '0;
    good_bytes = '0;
  endtask

  task automatic close_seq();
    if (enc_bytes(code_acc) != seq_len || !xml_char_ok(code_acc)) begin
      str_err = 1'b1;
    end else if (17'(good_bytes) + 17'(seq_len) > 17'h0_FFFF) begin
      good_bytes = '1;
    end else begin
      good_bytes = good_bytes + 16'(seq_len);
    end
    seq_left = '0;
    seq_len = '0;
    code_acc = '0;
  endtask

  task automatic absorb(input logic [7:0] b);
    if (str_err) return;
    if (b == 8'h00) begin
      str_err = 1'b1;
      return;
    end
    if (seq_left != 0) begin
      if ((b & CONT_TAG_MASK) != CONT_TAG) begin
        str_err = 1'b1;
        return;
      end
      code_acc = {code_acc[24:0], b[5:0]};
      seq_left = seq_left - 3'd1;
      if (seq_left == 0) close_seq();
      return;
    end
    casez (b)
      8'b0???????: begin
        seq_len = 3'd1;
        code_acc = 31'(b[6:0]);
      end
      8'b110?????: begin
        seq_len = 3'd2;
        code_acc = 31'(b[4:0]);
      end
      8'b1110????: begin
        seq_len = 3'd3;
        code_acc = 31'(b[3:0]);
      end
      8'b11110???: begin
        seq_len = 3'd4;
        code_acc = 31'(b[2:0]);
      end
      8'b111110??: begin
        seq_len = 3'd5;
        code_acc = 31'(b[1:0]);
      end
      8'b1111110?: begin
        seq_len = 3'd6;
        code_acc = 31'(b[0]);
      end
      default: begin
        str_err = 1'b1;
        return;
      end
    endcase
    seq_left = seq_len - 3'd1;
    if (seq_left == 0) close_seq();
  endtask

  task automatic end_string();
    verdict_t v;
    v.ok = !str_err && seq_left == 0;
    v.plen = good_bytes;
    verdict_q.push_back(v);
    clear_string();
  endtask

  task automatic report(input logic had_want, input verdict_t want);
    n_fail++;
    if (n_fail <= 10) begin
      if (had_want) begin
        $display("[%0t] verdict mismatch: expected valid_res=%0b prefix_length=%0d, got %0b %0d",
                 $time, want.ok, want.plen, valid_res, prefix_length);
      end else begin
        $display("[%0t] verdict with none pending: valid_res=%0b prefix_length=%0d",
                 $time, valid_res, prefix_length);
      end
    end
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      nul_mode = 1'b0;
      clear_string();
      verdict_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        if (nul_mode) begin
          if (data_byte == 8'h00) end_string();
          else absorb(data_byte);
        end else begin
          absorb(data_byte);
          if (last) end_string();
        end
      end
      if (out_valid && out_ready) begin
        n_done++;
        if (verdict_q.size() == 0) begin
          report(1'b0, '0);
        end else begin
          want = verdict_q.pop_front();
          if (want.ok != valid_res || want.plen != prefix_length) report(1'b1, want);
          if (valid_res) n_ok++;
        end
      end
      if (cfg_wr_en) nul_mode = cfg_wr_data;
    end
    fail_count <= n_fail;
    verdicts_due <= verdict_q.size();
    verdicts_done <= n_done;
    verdicts_ok <= n_ok;
  end

endmodule

FILE: dv/testbench.sv
// testbench: drives byte strings into utf8_xml_text_validator in both string modes,
// with bursty input and a stalling output; utf8x_checker predicts and compares.
// Depends on the validator RTL, utf8x_pkg and dv/utf8x_checker.sv.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 500_000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_WORDS = 240;
  localparam logic MODE_LEN = 1'b0;
  localparam logic MODE_NUL = 1'b1;

  localparam logic PH_MODE[4] = '{MODE_LEN, MODE_NUL, MODE_LEN, MODE_NUL};
  localparam int PH_GAP[4] = '{0, 6, 3, 10};
  localparam int PH_BURST[4] = '{1, 6, 12, 3};
  localparam int PH_STALL[4] = '{0, 1, 2, 1};

  localparam logic [31:0] BOUND_CP[12] = '{
    32'h7F, 32'h80, 32'h7FF, 32'h800, 32'hD7FF, 32'hE000,
    32'hFDCF, 32'hFDF0, 32'hFFFD, 32'h1_0000, 32'h10_FFFF, 32'h11_0000};
  localparam int BOUND_LEN[12] = '{1, 2, 2, 3, 3, 3, 3, 3, 3, 4, 4, 4};

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        last;
  logic        out_valid;
  logic        out_ready;
  logic        valid_res;
  logic [15:0] prefix_length;

  int fail_count;
  int verdicts_due;
  int verdicts_done;
  int verdicts_ok;

  logic [7:0] str_buf[$];
  logic       cur_nul;
  logic       hold_go;
  int         stall_mode;
  int         gap_max;
  int         burst_max;
  int         burst_left;
  int         words_sent;
  int         cycles;

  utf8_xml_text_validator u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .last         (last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .valid_res    (valid_res),
    .prefix_length(prefix_length)
  );

  utf8x_checker u_chk (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .last         (last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .valid_res    (valid_res),
    .prefix_length(prefix_length),
    .fail_count   (fail_count),
    .verdicts_due (verdicts_due),
    .verdicts_done(verdicts_done),
    .verdicts_ok  (verdicts_ok)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts still due", cycles, verdicts_due);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // output side: random ready pattern, plus one long hold-off
  initial begin
    int          pat_left;
    logic [31:0] pat;
    logic        hold_taken;
    pat_left = 0;
    pat = '0;
    hold_taken = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        if (pat_left == 0) begin
          pat = $urandom;
          pat_left = 30;
        end
        case (stall_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= pat[0] | pat[1];
          default: out_ready <= pat[0] & pat[1];
        endcase
        pat = pat >> 1;
        pat_left--;
      end
    end
  end

  task automatic send_word(input logic [7:0] b, input logic l);
    int   gap;
    logic rdy;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, burst_max);
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    data_byte <= b;
    last <= l;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    burst_left--;
    words_sent++;
  endtask

  task automatic send_str();
    int n;
    n = str_buf.size();
    for (int i = 0; i < n; i++) begin
      if (cur_nul) send_word(str_buf[i], (i == n - 2) ? 1'b1 : 1'($urandom_range(0, 1)));
      else send_word(str_buf[i], i == n - 1);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    last <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (verdicts_due != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_mode(input logic m);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    cur_nul = m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // one code point, mostly well formed, sometimes cut or corrupted, or a stray byte
  task automatic add_unit();
    logic [31:0] cp;
    logic [7:0]  seq[$];
    int          len;
    int          k;
    int          r;
    if ($urandom_range(0, 99) < 25) begin
      str_buf.push_back(8'($urandom_range(0, 255)));
      return;
    end
    len = 1;
    k = $urandom_range(0, 11);
    case (k)
      0: cp = $urandom_range(32'h20, 32'h7E);
      1: begin
        case ($urandom_range(0, 2))
          0: cp = 32'h09;
          1: cp = 32'h0A;
          default: cp = 32'h0D;
        endcase
      end
      2: cp = $urandom_range(0, 32'h1F);
      3: begin
        cp = $urandom_range(32'h80, 32'h7FF);
        len = 2;
      end
      4: begin
        cp = $urandom_range(32'h800, 32'hFFFF);
        len = 3;
      end
      5: begin
        cp = $urandom_range(32'h1_0000, 32'h10_FFFF);
        len = 4;
      end
      6: begin
        cp = $urandom_range(32'hD800, 32'hDFFF);
        len = 3;
      end
      7: begin
        cp = $urandom_range(32'hFDD0, 32'hFDEF);
        len = 3;
      end
      8: begin
        cp = ($urandom_range(0, 16) << 16) | 32'hFFFE | $urandom_range(0, 1);
        len = (cp < 32'h1_0000) ? 3 : 4;
      end
      9: begin
        cp = $urandom_range(0, 32'hFFFF);
        len = $urandom_range(2, 6);
      end
      10: begin
        cp = $urandom_range(32'h11_0000, 32'h7FFF_FFFF);
        len = $urandom_range(4, 6);
      end
      default: begin
        r = $urandom_range(0, 11);
        cp = BOUND_CP[r];
        len = BOUND_LEN[r];
      end
    endcase
    case (len)
      1: seq.push_back({1'b0, cp[6:0]});
      2: seq.push_back({3'b110, cp[10:6]});
      3: seq.push_back({4'b1110, cp[15:12]});
      4: seq.push_back({5'b11110, cp[20:18]});
      5: seq.push_back({6'b111110, cp[25:24]});
      default: seq.push_back({7'b1111110, cp[30]});
    endcase
    for (int j = len - 2; j >= 0; j--) seq.push_back({2'b10, 6'(cp >> (6 * j))});
    r = $urandom_range(0, 99);
    if (r < 6 && len > 1) begin
      repeat ($urandom_range(1, len - 1)) void'(seq.pop_back());
    end else if (r < 10 && len > 1) begin
      seq[$urandom_range(1, len - 1)] = 8'($urandom_range(0, 255));
    end
    foreach (seq[j]) str_buf.push_back(seq[j]);
  endtask

  task automatic build_string();
    int units;
    str_buf.delete();
    units = (cur_nul && $urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 8);
    repeat (units) add_unit();
    if (cur_nul) str_buf.push_back(8'h00);
  endtask

  initial begin
    int target;
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= 1'b0;
    in_valid <= 1'b0;
    data_byte <= 8'h00;
    last <= 1'b0;
    hold_go <= 1'b0;
    stall_mode <= 1;
    cur_nul = MODE_LEN;
    gap_max = 2;
    burst_max = 4;
    burst_left = 0;
    words_sent = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed strings, length mode
    set_mode(MODE_LEN);
    str_buf = '{8'hFF};
    send_str();
    str_buf = '{8'h41, 8'hE2, 8'h41};
    send_str();
    str_buf = '{8'h00};
    send_str();
    str_buf = '{8'hF0, 8'h9F, 8'h98};
    send_str();
    str_buf = '{8'h80, 8'h7F};
    send_str();
    str_buf = '{8'hC3, 8'hA9, 8'h0A};
    send_str();
    // zero-terminated mode: last flag ignored, cut sequence, mode change mid-string
    set_mode(MODE_NUL);
    str_buf = '{8'h41, 8'h42, 8'h43, 8'h00};
    send_str();
    str_buf = '{8'hE2, 8'h82, 8'h00};
    send_str();
    str_buf = '{8'h61};
    send_str();
    set_mode(MODE_LEN);
    str_buf = '{8'h62};
    send_str();

    for (int p = 0; p < 4; p++) begin
      set_mode(PH_MODE[p]);
      gap_max = PH_GAP[p];
      burst_max = PH_BURST[p];
      stall_mode <= PH_STALL[p];
      if (p == 1) hold_go <= 1'b1;
      target = words_sent + PHASE_WORDS;
      while (words_sent < target) begin
        build_string();
        send_str();
      end
    end
    drain();
    repeat (8) @(posedge clk);

    $display("Summary: %0d words in length and zero-terminated modes, %0d verdicts (%0d valid)",
             words_sent, verdicts_done, verdicts_ok);
    $display("  incl. cut, overlong and stray-byte strings and a %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (fail_count == 0 && verdicts_due == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d verdicts never returned", fail_count, verdicts_due);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
